// ===== hw/rtl/vl2n_pkg.sv =====
// ----------------------------------------------------------------------------
// vl2n_pkg
// Shared types and constants of the L2 vector normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package vl2n_pkg;

    localparam int DATA_W      = 16;
    localparam int SUM_W       = 38;
    localparam int MAX_LEN_DEF = 64;
    localparam int QUO_W       = 31;
    localparam int REM_W       = SUM_W + 1;
    localparam int DIV_STEPS   = QUO_W;
    localparam int SQRT_STEPS  = 16;
    localparam int STEP_W      = 5;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SUM,
        S_RD,
        S_FETCH,
        S_MUL,
        S_DIV,
        S_SQI,
        S_SQRT,
        S_FIN,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr;
        logic rd;
        logic fetch;
        logic mul;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic fin;
        logic next;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_elem;
    } t_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/vl2n_ram.sv =====
// ----------------------------------------------------------------------------
// vl2n_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module vl2n_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/vl2n_ctrl.sv =====
// ----------------------------------------------------------------------------
// vl2n_ctrl
// Sequencer: loads a vector, then runs divide and square root per element.
// ----------------------------------------------------------------------------
`default_nettype none
module vl2n_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    input  wire logic          i_out_ready,
    input  vl2n_pkg::t_sts     i_sts,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output vl2n_pkg::t_cmd     o_cmd
);
    import vl2n_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step,  n_step;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:  if (i_in_valid && i_in_last) n_state = S_SUM;
            S_SUM:   n_state = S_RD;
            S_RD:    n_state = S_FETCH;
            S_FETCH: n_state = S_MUL;
            S_MUL:   n_state = S_DIV;
            S_DIV:   if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = S_SQI;
            S_SQI:   n_state = S_SQRT;
            S_SQRT:  if (r_step == STEP_W'(SQRT_STEPS - 1)) n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = i_sts.last_elem ? S_LOAD : S_RD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // iteration counter
    always_comb begin
        n_step = '0;
        if ((r_state == S_DIV && n_state == S_DIV) ||
            (r_state == S_SQRT && n_state == S_SQRT)) begin
            n_step = r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SUM:   ;
            S_RD:    o_cmd.rd        = 1'b1;
            S_FETCH: o_cmd.fetch     = 1'b1;
            S_MUL:   o_cmd.mul       = 1'b1;
            S_DIV:   o_cmd.div_step  = 1'b1;
            S_SQI:   o_cmd.sqrt_init = 1'b1;
            S_SQRT:  o_cmd.sqrt_step = 1'b1;
            S_FIN:   o_cmd.fin       = 1'b1;
            S_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.next  = i_out_ready && !i_sts.last_elem;
                o_cmd.clr   = i_out_ready && i_sts.last_elem;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/vl2n_dp.sv =====
// ----------------------------------------------------------------------------
// vl2n_dp
// Datapath: element store, square sum, restoring divider, digit square root.
// ----------------------------------------------------------------------------
`default_nettype none
module vl2n_dp #(
    parameter int MAX_LEN = vl2n_pkg::MAX_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  vl2n_pkg::t_cmd                     i_cmd,
    input  wire logic [vl2n_pkg::DATA_W-1:0]   i_elem,
    output vl2n_pkg::t_sts                     o_sts,
    output logic      [vl2n_pkg::DATA_W-1:0]   o_norm,
    output logic                               o_last,
    output logic                               o_zero
);
    import vl2n_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0]        r_cnt, r_idx;
    logic [SUM_W-1:0]     r_sum;
    logic [2*DATA_W-1:0]  r_sq;
    logic                 r_add;
    logic [DATA_W-1:0]    rd_data;
    logic [DATA_W-1:0]    r_mag;
    logic                 r_neg;
    logic [REM_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_nlow, r_quo;
    logic [QUO_W:0]       r_a;
    logic [17:0]          r_srem;
    logic [15:0]          r_root;

    logic                 not_full;
    logic [DATA_W-1:0]    in_mag;
    logic [2*DATA_W-1:0]  prod;
    logic [REM_W-1:0]     div_t;
    logic [19:0]          sq_t, sq_trial;

    assign not_full = (r_cnt < CW'(MAX_LEN));
    assign in_mag   = i_elem[DATA_W-1] ? (~i_elem + DATA_W'(1)) : i_elem;
    assign prod     = r_mag * r_mag;
    assign div_t    = {r_rem[REM_W-2:0], r_nlow[QUO_W-1]};
    assign sq_t     = {r_srem, r_a[QUO_W:QUO_W-1]};
    assign sq_trial = {2'b00, r_root, 2'b01};

    assign o_sts.last_elem = (r_idx == r_cnt - CW'(1));

    vl2n_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && not_full),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_elem),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // count, index and square sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
            r_sum <= '0;
            r_add <= 1'b0;
        end else begin
            r_add <= i_cmd.load && not_full;
            if (i_cmd.load && not_full) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (r_add) begin
                r_sum <= r_sum + SUM_W'(r_sq);
            end
            if (i_cmd.next) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.clr) begin
                r_cnt <= '0;
                r_idx <= '0;
                r_sum <= '0;
            end
        end
    end

    // square the incoming element
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sq <= in_mag * in_mag;
        end
    end

    // per-element divide and square root
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_neg <= rd_data[DATA_W-1];
            r_mag <= rd_data[DATA_W-1] ? (~rd_data + DATA_W'(1)) : rd_data;
        end
        if (i_cmd.mul) begin
            r_rem  <= REM_W'(prod[2*DATA_W-1:1]);
            r_nlow <= {prod[0], {(QUO_W-1){1'b0}}};
            r_quo  <= '0;
        end
        if (i_cmd.div_step) begin
            r_nlow <= {r_nlow[QUO_W-2:0], 1'b0};
            if (div_t >= {1'b0, r_sum}) begin
                r_rem <= div_t - {1'b0, r_sum};
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= div_t;
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
        if (i_cmd.sqrt_init) begin
            r_a    <= {1'b0, r_quo};
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_a <= {r_a[QUO_W-2:0], 2'b00};
            if (sq_t >= sq_trial) begin
                r_srem <= 18'(sq_t - sq_trial);
                r_root <= {r_root[14:0], 1'b1};
            end else begin
                r_srem <= sq_t[17:0];
                r_root <= {r_root[14:0], 1'b0};
            end
        end
        // zero a zero-sum vector, sign, saturate and hold the result beat
        if (i_cmd.fin) begin
            o_last <= o_sts.last_elem;
            o_zero <= (r_sum == '0);
            if (r_sum == '0) begin
                o_norm <= '0;
            end else if (r_neg) begin
                o_norm <= ~r_root + 16'd1;
            end else begin
                o_norm <= r_root[15] ? 16'h7FFF : r_root;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/vector_l2_normalizer.sv =====
// Element beats are stored as they arrive; after the last one a sum state
// settles the square sum. Each result then passes read, fetch, square,
// a divider step per quotient bit, root setup, a root step per root bit,
// finish and the output beat. Input is held off while a vector is emitted.
// Reset (synchronous, active low) empties the vector and the square sum.
// ----------------------------------------------------------------------------
// vector_l2_normalizer
// Top level: L2 normalization of a streamed signed 16-bit vector.
// ----------------------------------------------------------------------------
`default_nettype none
module vector_l2_normalizer #(
    parameter int MAX_LEN = vl2n_pkg::MAX_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] elem_value
    input  wire logic        s_axis_tlast,   // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [15:0] norm_value
    output logic             m_axis_tlast,   // last_out
    output logic             m_axis_tuser    // [0] zero_norm
);
    import vl2n_pkg::*;

    t_cmd cmd;
    t_sts sts;

    vl2n_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    vl2n_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_elem  (s_axis_tdata),
        .o_sts   (sts),
        .o_norm  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_zero  (m_axis_tuser)
    );
endmodule
`default_nettype wire
